@@ src/slts_pkg.sv @@
// Shared types, constants and byte classifier for the source lexer token splitter.
package slts_pkg;

   localparam int MaxTokenLenDefault = 128;
   localparam int LineBitsDefault    = 16;

   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   typedef enum logic [2:0] {
      TOK_WORD,
      TOK_NUM,
      TOK_SEMI,
      TOK_COMMA,
      TOK_BRACKET,
      TOK_OTHER,
      TOK_CHARLIT,
      TOK_STRLIT
   } tok_kind_type;

   typedef enum logic [1:0] {
      RES_APPEND,
      RES_DONE,
      RES_TOO_LONG
   } res_kind_type;

   typedef struct packed {
      res_kind_type kind;
      tok_kind_type tok;
      logic [7:0]   char_val;
      logic [7:0]   len;
      logic [15:0]  line;
      logic         last;
   } result_type;

   function automatic tok_kind_type classify(input logic [7:0] b);
      tok_kind_type t;
      case (b) inside
         [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER: t = TOK_WORD;
         [8'h30:8'h39], CH_MINUS:                t = TOK_NUM;
         CH_SEMI:                                t = TOK_SEMI;
         CH_COMMA:                               t = TOK_COMMA;
         CH_LPAREN, CH_RPAREN, CH_LSQUARE, CH_RSQUARE, CH_LBRACE, CH_RBRACE:
                                                 t = TOK_BRACKET;
         default:                                t = TOK_OTHER;
      endcase
      return t;
   endfunction

endpackage

@@ src/source_lexer_token_splitter.sv @@
// Source lexer token splitter: byte classification, token grouping and result queue.
//
// Usage: source bytes enter on the req_ channel (req_mode 0) one beat at a time; a beat
// with req_mode 1 marks end of input, closes any open token and clears all lexer state.
// Each accepted beat gives zero, one or two result beats on the rsp_ channel: appended
// characters, token-complete markers with their length, or a single too-long error,
// each tagged with the current line number; rsp_last_of_run marks the final result
// of a given input beat.
// Each beat's results are registered into the result queue as the beat is accepted and
// reach rsp_ behind any older results. Throughput: one input beat per cycle while
// req_stall is low; all lexing is one pass of logic at the input that writes straight
// into a four-entry result queue. The queue drains one result per cycle while rsp_stall
// is low. req_stall rises while fewer than two queue entries are free.
// Reset (synchronous) empties the queue and clears the quote, comment, token, line
// and error state. When rsp_stall is held, results wait in the queue unchanged and
// input is taken until fewer than two queue entries are free.
module source_lexer_token_splitter
   import slts_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = MaxTokenLenDefault,
   parameter int LINE_BITS     = LineBitsDefault
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_byte_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_token_type,
   output logic [7:0]  rsp_char_value,
   output logic [7:0]  rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last_of_run
);

   localparam logic [7:0] MaxLen = 8'(MAX_TOKEN_LEN);
   localparam int FifoDepth = 4;
   localparam int PtrBits   = $clog2(FifoDepth);
   localparam int CntBits   = $clog2(FifoDepth + 1);

   // lexer state
   logic                 comment_ff, comment_in;
   logic                 squote_ff, squote_in;
   logic                 dquote_ff, dquote_in;
   logic                 open_ff, open_in;
   logic [7:0]           len_ff, len_in;
   tok_kind_type         type_ff, type_in;
   logic [LINE_BITS-1:0] line_count_ff, line_count_in;
   logic                 error_hold_ff, error_hold_in;

   // result queue
   result_type           fifo_ff [FifoDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;

   logic                 accept;
   logic                 pop;
   logic [1:0]           push_n;
   result_type           res0, res1;
   logic                 quoted;
   tok_kind_type         tok;
   logic [7:0]           len_base;
   logic [31:0]          line_wide;
   logic [PtrBits-1:0]   wr_ptr_next;

   assign req_stall = count_ff > CntBits'(FifoDepth - 2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      comment_in    = comment_ff;
      squote_in     = squote_ff;
      dquote_in     = dquote_ff;
      open_in       = open_ff;
      len_in        = len_ff;
      type_in       = type_ff;
      line_count_in = line_count_ff;
      error_hold_in = error_hold_ff;
      push_n        = 2'd0;
      res0          = '0;
      res1          = '0;
      quoted        = squote_ff || dquote_ff;
      len_base      = '0;
      line_wide     = 32'(line_count_ff);

      if (squote_ff) begin
         tok = TOK_CHARLIT;
      end else if (dquote_ff) begin
         tok = TOK_STRLIT;
      end else begin
         tok = classify(req_byte_value);
      end

      if (req_mode) begin
         if (!error_hold_ff && open_ff) begin
            res0 = '{kind: RES_DONE, tok: type_ff, char_val: 8'd0, len: len_ff,
                     line: line_wide[15:0], last: 1'b1};
            push_n = 2'd1;
         end
         comment_in    = 1'b0;
         squote_in     = 1'b0;
         dquote_in     = 1'b0;
         open_in       = 1'b0;
         len_in        = '0;
         type_in       = TOK_WORD;
         line_count_in = '0;
         error_hold_in = 1'b0;
      end else if (error_hold_ff) begin
         push_n = 2'd0;
      end else if (req_byte_value == CH_SQUOTE) begin
         squote_in = !squote_ff;
      end else if (req_byte_value == CH_DQUOTE) begin
         dquote_in = !dquote_ff;
      end else if (req_byte_value == CH_COLON && !quoted) begin
         comment_in = !comment_ff;
      end else if (comment_ff && !quoted) begin
         push_n = 2'd0;
      end else if ((req_byte_value != CH_SPACE && req_byte_value != CH_NEWLINE)
                   || quoted) begin
         if (open_ff && type_ff != tok) begin
            res0 = '{kind: RES_DONE, tok: type_ff, char_val: 8'd0, len: len_ff,
                     line: line_wide[15:0], last: 1'b0};
            push_n = 2'd1;
         end
         len_base = (open_ff && type_ff == tok) ? len_ff : 8'd0;
         open_in  = 1'b1;
         type_in  = tok;
         if (len_base >= MaxLen) begin
            res1 = '{kind: RES_TOO_LONG, tok: tok, char_val: 8'd0, len: 8'd0,
                     line: line_wide[15:0], last: 1'b1};
            len_in        = len_base;
            error_hold_in = 1'b1;
         end else begin
            res1 = '{kind: RES_APPEND, tok: tok, char_val: req_byte_value, len: 8'd0,
                     line: line_wide[15:0], last: 1'b1};
            len_in = len_base + 8'd1;
         end
         if (push_n == 2'd0) begin
            res0   = res1;
            push_n = 2'd1;
         end else begin
            push_n = 2'd2;
         end
      end else if (open_ff) begin
         if (req_byte_value == CH_NEWLINE && line_count_ff != {LINE_BITS{1'b1}}) begin
            line_count_in = line_count_ff + LINE_BITS'(1);
         end
         line_wide = 32'(line_count_in);
         res0 = '{kind: RES_DONE, tok: type_ff, char_val: 8'd0, len: len_ff,
                  line: line_wide[15:0], last: 1'b1};
         push_n  = 2'd1;
         open_in = 1'b0;
      end

      if (!accept) begin
         push_n = 2'd0;
      end

      wr_ptr_next = wr_ptr_ff + PtrBits'(1);
      wr_ptr_in   = wr_ptr_ff + PtrBits'(push_n);
      rd_ptr_in   = rd_ptr_ff + PtrBits'(pop);
      count_in    = count_ff + CntBits'(push_n) - CntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff    <= 1'b0;
         squote_ff     <= 1'b0;
         dquote_ff     <= 1'b0;
         open_ff       <= 1'b0;
         len_ff        <= '0;
         type_ff       <= TOK_WORD;
         line_count_ff <= '0;
         error_hold_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (accept) begin
            comment_ff    <= comment_in;
            squote_ff     <= squote_in;
            dquote_ff     <= dquote_in;
            open_ff       <= open_in;
            len_ff        <= len_in;
            type_ff       <= type_in;
            line_count_ff <= line_count_in;
            error_hold_ff <= error_hold_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_next] <= res1;
      end
   end

   assign rsp_result_kind  = fifo_ff[rd_ptr_ff].kind;
   assign rsp_token_type   = fifo_ff[rd_ptr_ff].tok;
   assign rsp_char_value   = fifo_ff[rd_ptr_ff].char_val;
   assign rsp_token_length = fifo_ff[rd_ptr_ff].len;
   assign rsp_line_number  = fifo_ff[rd_ptr_ff].line;
   assign rsp_last_of_run  = fifo_ff[rd_ptr_ff].last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(FifoDepth))
      else $error("result queue over capacity");

   a_error_needs_token: assert property (@(posedge clock) disable iff (reset)
      error_hold_ff |-> open_ff)
      else $error("error hold without an open token");

   a_eoi_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode |=> !open_ff && !error_hold_ff && !comment_ff
                             && line_count_ff == '0)
      else $error("end of input did not clear state");

   a_no_push_on_full: assert property (@(posedge clock) disable iff (reset)
      count_ff > CntBits'(FifoDepth - 2) |-> push_n == 2'd0)
      else $error("push into a nearly full result queue");

endmodule
